/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif

`endif

/* src/gvce_pkg.sv */
// ----------------------------------------------------------------------------
// Graph vertex contraction engine package
// Command and result words, opcodes, status codes, controller states, sweep modes and memory controls.
// ----------------------------------------------------------------------------
package gvce_pkg;

  localparam int MaxVerticesDef = 16;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_WRITE    = 3'd1,
    OP_READ     = 3'd2,
    OP_DELETE   = 3'd3,
    OP_MERGE    = 3'd4,
    OP_CONTRACT = 3'd5,
    OP_SPLIT    = 3'd6,
    OP_NONE     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BAD    = 3'd1,
    ST_NOEDGE = 3'd2,
    ST_FULL   = 3'd3,
    ST_SAME   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_CHECK,
    S_SWEEP,
    S_TAIL,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    MODE_WRITE,
    MODE_SPLIT,
    MODE_SHIFT
  } mode_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  vertex_a;
    logic [3:0]  vertex_b;
    logic [15:0] row_in;
    logic [4:0]  new_count;
  } cmd_t;

  typedef struct packed {
    logic [15:0] row_out;
    logic [4:0]  vertex_count;
    logic [2:0]  status;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

/* src/gvce_row_mem.sv */
// ----------------------------------------------------------------------------
// Adjacency row memory
// One read and one write port, registered read, per-row valid bits that
// reset and a clear command drop at once; an invalid row reads as zero.
// ----------------------------------------------------------------------------
module gvce_row_mem #(
  parameter int Depth = gvce_pkg::MaxVerticesDef,
  parameter int Width = gvce_pkg::MaxVerticesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gvce_pkg::mem_ctl_t       ctl_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] rows_q [Depth];
  logic [Width-1:0] rd_data_q;
  logic [Depth-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      rows_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= rows_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* src/graph_vertex_contraction_engine.sv */
// ----------------------------------------------------------------------------
// Graph vertex contraction engine
// Symmetric adjacency matrix held in a row memory, edited by row sweeps.
// ----------------------------------------------------------------------------
// Read, clear/size, unused opcode and all errors end without a row sweep.
// Write row, delete/merge/contract and split read-modify-write the live rows
// through the memory's read and write ports; all but write row add a tail write.
// Result strobe done_o comes in the last busy cycle; no stall from the sink.
// Reset drops every row valid bit at once, so the graph is empty at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module graph_vertex_contraction_engine #(
  parameter int MaxVertices = gvce_pkg::MaxVerticesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  gvce_pkg::cmd_t cmd_i,
  output logic           done_o,
  output gvce_pkg::res_t result_o
);

  localparam int RowW = MaxVertices;
  localparam int IdxW = $clog2(MaxVertices);
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int CmpW = (CntW > 4) ? CntW : 4;
  localparam int NcW  = (CntW > 5) ? CntW : 5;

  function automatic logic [RowW-1:0] mask_below(input logic [CntW-1:0] n);
    logic [RowW-1:0] m;
    for (int j = 0; j < RowW; j++) begin
      m[j] = (CntW'(j) < n);
    end
    return m;
  endfunction

  function automatic logic [RowW-1:0] bit_at(input logic [IdxW-1:0] k);
    return RowW'(1) << k;
  endfunction

  function automatic logic [RowW-1:0] drop_bit(input logic [RowW-1:0] r,
                                               input logic [IdxW-1:0] k);
    logic [RowW-1:0] low;
    low = bit_at(k) - RowW'(1);
    return (r & low) | ((r >> 1) & ~low);
  endfunction

  gvce_pkg::state_e  state_q, state_d;
  gvce_pkg::cmd_t    cmd_q, cmd_d;
  gvce_pkg::mode_e   mode_q, mode_d;
  gvce_pkg::status_e status_q, status_d;
  logic [CntW-1:0]   live_q, live_d;
  logic [CntW-1:0]   live_new_q, live_new_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   limit_q, limit_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_dst_q, pend_dst_d;
  logic [IdxW-1:0]   pend_src_q, pend_src_d;
  logic [IdxW-1:0]   report_q, report_d;
  logic [IdxW-1:0]   v_q, v_d;
  logic              merge_q, merge_d;
  logic              tail_q, tail_d;
  logic [IdxW-1:0]   tail_addr_q, tail_addr_d;
  logic [RowW-1:0]   tail_data_q, tail_data_d;
  logic [RowW-1:0]   ra_q, ra_d;
  logic [RowW-1:0]   rb_q, rb_d;
  logic [RowW-1:0]   rmask_q, rmask_d;
  logic [RowW-1:0]   row_q, row_d;

  gvce_pkg::mem_ctl_t mem_ctl;
  logic [IdxW-1:0]    rd_addr, wr_addr;
  logic [RowW-1:0]    wr_data, rd_row;

  logic              a_ok, b_ok, same, full, has_edge, go_sweep;
  gvce_pkg::status_e chk_status;
  logic [IdxW-1:0]   a_idx, b_idx, n_idx, src_idx;
  logic [CntW-1:0]   live_m1, live_sat;
  logic [RowW-1:0]   rb_eff, r_masked, wdata;

  gvce_row_mem #(
    .Depth(MaxVertices),
    .Width(RowW)
  ) u_row_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_data_o(rd_row)
  );

  assign a_idx    = IdxW'(cmd_q.vertex_a);
  assign b_idx    = IdxW'(cmd_q.vertex_b);
  assign n_idx    = live_q[IdxW-1:0];
  assign a_ok     = CmpW'(cmd_q.vertex_a) < CmpW'(live_q);
  assign b_ok     = CmpW'(cmd_q.vertex_b) < CmpW'(live_q);
  assign same     = cmd_q.vertex_a == cmd_q.vertex_b;
  assign full     = live_q == CntW'(MaxVertices);
  assign has_edge = ra_q[b_idx];
  assign live_m1  = live_q - CntW'(1);
  assign live_sat = (NcW'(cmd_q.new_count) > NcW'(MaxVertices)) ? CntW'(MaxVertices)
                                                                : CntW'(cmd_q.new_count);
  assign rb_eff   = (cmd_q.opcode == gvce_pkg::OP_CONTRACT) ? (rd_row & ~bit_at(a_idx))
                                                            : rd_row;
  assign r_masked = RowW'(cmd_q.row_in) & mask_below(live_q);
  assign src_idx  = ((mode_q == gvce_pkg::MODE_SHIFT) && (rd_idx_q >= CntW'(v_q)))
                    ? (rd_idx_q[IdxW-1:0] + IdxW'(1)) : rd_idx_q[IdxW-1:0];

  always_comb begin
    go_sweep   = 1'b0;
    chk_status = gvce_pkg::ST_OK;
    case (cmd_q.opcode)
      gvce_pkg::OP_WRITE, gvce_pkg::OP_DELETE: begin
        if (!a_ok) chk_status = gvce_pkg::ST_BAD;
        else go_sweep = 1'b1;
      end
      gvce_pkg::OP_READ: begin
        if (!a_ok) chk_status = gvce_pkg::ST_BAD;
      end
      gvce_pkg::OP_MERGE, gvce_pkg::OP_CONTRACT: begin
        if (!a_ok || !b_ok) chk_status = gvce_pkg::ST_BAD;
        else if (same) chk_status = gvce_pkg::ST_SAME;
        else if ((cmd_q.opcode == gvce_pkg::OP_CONTRACT) && !has_edge) begin
          chk_status = gvce_pkg::ST_NOEDGE;
        end else go_sweep = 1'b1;
      end
      gvce_pkg::OP_SPLIT: begin
        if (!a_ok) chk_status = gvce_pkg::ST_BAD;
        else if (full) chk_status = gvce_pkg::ST_FULL;
        else go_sweep = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    logic [RowW-1:0] m;
    m     = rd_row;
    wdata = rd_row;
    case (mode_q)
      gvce_pkg::MODE_WRITE: begin
        if (pend_dst_q == a_idx) begin
          wdata = rmask_q;
        end else begin
          wdata[a_idx] = rmask_q[pend_dst_q];
        end
      end
      gvce_pkg::MODE_SPLIT: begin
        if (ra_q[pend_dst_q]) wdata = rd_row | bit_at(n_idx);
        if (pend_dst_q == a_idx) wdata[a_idx] = 1'b0;
      end
      gvce_pkg::MODE_SHIFT: begin
        if (merge_q) begin
          if (pend_src_q == a_idx) m = rd_row | rb_q;
          else if (rb_q[pend_src_q]) m[a_idx] = 1'b1;
        end
        wdata = drop_bit(m, v_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gvce_pkg::S_IDLE:  if (start) state_d = gvce_pkg::S_RD_A;
      gvce_pkg::S_RD_A:  state_d = gvce_pkg::S_RD_B;
      gvce_pkg::S_RD_B:  state_d = gvce_pkg::S_CHECK;
      gvce_pkg::S_CHECK: state_d = go_sweep ? gvce_pkg::S_SWEEP : gvce_pkg::S_DONE;
      gvce_pkg::S_SWEEP: begin
        if (rd_idx_q == limit_q) state_d = tail_q ? gvce_pkg::S_TAIL : gvce_pkg::S_DONE;
      end
      gvce_pkg::S_TAIL:  state_d = gvce_pkg::S_DONE;
      gvce_pkg::S_DONE:  state_d = gvce_pkg::S_IDLE;
      default:           state_d = gvce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    mode_d      = mode_q;
    status_d    = status_q;
    live_d      = live_q;
    live_new_d  = live_new_q;
    rd_idx_d    = rd_idx_q;
    limit_d     = limit_q;
    pend_d      = pend_q;
    pend_dst_d  = pend_dst_q;
    pend_src_d  = pend_src_q;
    report_d    = report_q;
    v_d         = v_q;
    merge_d     = merge_q;
    tail_d      = tail_q;
    tail_addr_d = tail_addr_q;
    tail_data_d = tail_data_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    rmask_d     = rmask_q;
    row_d       = row_q;
    mem_ctl     = '0;
    rd_addr     = '0;
    wr_addr     = '0;
    wr_data     = '0;
    case (state_q)
      gvce_pkg::S_IDLE: begin
        if (start) cmd_d = cmd_i;
      end
      gvce_pkg::S_RD_A: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = a_idx;
      end
      gvce_pkg::S_RD_B: begin
        ra_d          = rd_row;
        mem_ctl.rd_en = 1'b1;
        rd_addr       = b_idx;
      end
      gvce_pkg::S_CHECK: begin
        rb_d        = rb_eff;
        rmask_d     = r_masked;
        rd_idx_d    = '0;
        pend_d      = 1'b0;
        status_d    = chk_status;
        row_d       = (go_sweep || !a_ok) ? '0 : ra_q;
        report_d    = a_idx;
        merge_d     = 1'b0;
        v_d         = a_idx;
        tail_d      = 1'b1;
        tail_addr_d = live_m1[IdxW-1:0];
        tail_data_d = '0;
        live_new_d  = live_m1;
        limit_d     = live_m1;
        mode_d      = gvce_pkg::MODE_SHIFT;
        case (cmd_q.opcode)
          gvce_pkg::OP_CLEAR: begin
            mem_ctl.clr = 1'b1;
            live_d      = live_sat;
            row_d       = '0;
          end
          gvce_pkg::OP_WRITE: begin
            mode_d  = gvce_pkg::MODE_WRITE;
            limit_d = live_q;
            tail_d  = 1'b0;
          end
          gvce_pkg::OP_MERGE, gvce_pkg::OP_CONTRACT: begin
            v_d      = b_idx;
            merge_d  = 1'b1;
            report_d = (a_idx > b_idx) ? (a_idx - IdxW'(1)) : a_idx;
          end
          gvce_pkg::OP_SPLIT: begin
            mode_d      = gvce_pkg::MODE_SPLIT;
            limit_d     = live_q;
            tail_addr_d = n_idx;
            tail_data_d = ra_q;
            live_new_d  = live_q + CntW'(1);
          end
          default: ;
        endcase
      end
      gvce_pkg::S_SWEEP: begin
        if (pend_q) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = pend_dst_q;
          wr_data       = wdata;
          if (pend_dst_q == report_q) row_d = wdata;
        end
        if (rd_idx_q != limit_q) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = src_idx;
          pend_d        = 1'b1;
          pend_dst_d    = rd_idx_q[IdxW-1:0];
          pend_src_d    = src_idx;
          rd_idx_d      = rd_idx_q + CntW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      gvce_pkg::S_TAIL: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = tail_addr_q;
        wr_data       = tail_data_q;
        live_d        = live_new_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gvce_pkg::S_IDLE;
      live_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    mode_q      <= mode_d;
    status_q    <= status_d;
    live_new_q  <= live_new_d;
    rd_idx_q    <= rd_idx_d;
    limit_q     <= limit_d;
    pend_dst_q  <= pend_dst_d;
    pend_src_q  <= pend_src_d;
    report_q    <= report_d;
    v_q         <= v_d;
    merge_q     <= merge_d;
    tail_q      <= tail_d;
    tail_addr_q <= tail_addr_d;
    tail_data_q <= tail_data_d;
    ra_q        <= ra_d;
    rb_q        <= rb_d;
    rmask_q     <= rmask_d;
    row_q       <= row_d;
  end

  assign busy                  = state_q != gvce_pkg::S_IDLE;
  assign done_o                = state_q == gvce_pkg::S_DONE;
  assign result_o.row_out      = 16'(row_q);
  assign result_o.vertex_count = 5'(live_q);
  assign result_o.status       = status_q;

  `ASSERT_STD(a_done_pulse, done_o |=> !done_o, "result strobe held past one cycle")
  `ASSERT_STD(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `ASSERT_STD(a_no_rw_clash, !(mem_ctl.rd_en && mem_ctl.wr_en && (rd_addr == wr_addr)), "row read and write hit one address")
  `ASSERT_STD(a_live_update, (live_q != $past(live_q)) |-> (($past(state_q) == gvce_pkg::S_CHECK) || ($past(state_q) == gvce_pkg::S_TAIL)), "vertex count moved outside check or tail")

endmodule
